/* rtl/core/cpu_bus_address_decoder_assert.svh */
// ----------------------------------------------------------------------------
// CPU bus address decoder assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_ADDRESS_DECODER_ASSERT_SVH
`define CPU_BUS_ADDRESS_DECODER_ASSERT_SVH

// same-cycle implication
`define CBAD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbad: same-cycle check failed");

// next-cycle implication
`define CBAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbad: next-cycle check failed");

`endif

/* rtl/core/cbad_pkg.sv */
// ----------------------------------------------------------------------------
// cbad_pkg
// Types, address map constants and target codes of the CPU bus decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

  localparam int RAM_ADDR_BITS = 11;
  localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;
  localparam int DATA_W        = 8;
  localparam int ADDR_W        = 16;

  localparam logic REQ_WRITE = 1'b1;

  localparam logic [ADDR_W-1:0] RAM_END      = 16'h1FFF;
  localparam logic [ADDR_W-1:0] PPU_END      = 16'h3FFF;
  localparam logic [ADDR_W-1:0] PPU_REG_MASK = 16'h0007;
  localparam logic [ADDR_W-1:0] APU_END      = 16'h4013;
  localparam logic [ADDR_W-1:0] DMA_ADDR     = 16'h4014;
  localparam logic [ADDR_W-1:0] APU_STATUS   = 16'h4015;
  localparam logic [ADDR_W-1:0] PAD0_ADDR    = 16'h4016;
  localparam logic [ADDR_W-1:0] PAD1_ADDR    = 16'h4017;
  localparam logic [ADDR_W-1:0] MAPPER_BASE  = 16'h4800;

  typedef enum logic [2:0] {
    TGT_RAM      = 3'd0,
    TGT_PPU      = 3'd1,
    TGT_PAD      = 3'd2,
    TGT_APU      = 3'd3,
    TGT_DMA      = 3'd4,
    TGT_MAPPER   = 3'd5,
    TGT_UNMAPPED = 3'd6
  } target_t;

  typedef struct packed {
    target_t             target;
    logic [ADDR_W-1:0]   fwd_addr;
    logic                fwd_data;   // pass write byte on
    logic                ram_rd;
    logic                ram_wr;
    logic                pad_rd;
    logic                pad_sel;
    logic                pad_strobe;
    logic                dma;
  } dec_t;

endpackage

/* rtl/core/cbad_ram.sv */
// ----------------------------------------------------------------------------
// cbad_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/cbad_decode.sv */
// ----------------------------------------------------------------------------
// cbad_decode
// Address map decode of one CPU bus access into target and action flags.
// ----------------------------------------------------------------------------
module cbad_decode (
  input  logic                        req_type,
  input  logic [cbad_pkg::ADDR_W-1:0] address,
  output cbad_pkg::dec_t              dec
);

  logic wr;

  assign wr = (req_type == cbad_pkg::REQ_WRITE);

  always_comb begin
    dec            = '0;
    dec.target     = cbad_pkg::TGT_UNMAPPED;
    dec.fwd_addr   = address;
    dec.pad_sel    = address[0];
    if (address <= cbad_pkg::RAM_END) begin
      dec.target = cbad_pkg::TGT_RAM;
      dec.ram_wr = wr;
      dec.ram_rd = !wr;
    end else if (address <= cbad_pkg::PPU_END) begin
      dec.target   = cbad_pkg::TGT_PPU;
      dec.fwd_addr = address & cbad_pkg::PPU_REG_MASK;
      dec.fwd_data = wr;
    end else if (address >= cbad_pkg::MAPPER_BASE) begin
      dec.target   = cbad_pkg::TGT_MAPPER;
      dec.fwd_data = wr;
    end else if (!wr) begin
      if (address == cbad_pkg::PAD0_ADDR || address == cbad_pkg::PAD1_ADDR) begin
        dec.target = cbad_pkg::TGT_PAD;
        dec.pad_rd = 1'b1;
      end
    end else begin
      // 0x4017 write goes to the APU frame counter, not pad 1
      if (address <= cbad_pkg::APU_END || address == cbad_pkg::APU_STATUS ||
          address == cbad_pkg::PAD1_ADDR) begin
        dec.target   = cbad_pkg::TGT_APU;
        dec.fwd_data = 1'b1;
      end else if (address == cbad_pkg::DMA_ADDR) begin
        dec.target = cbad_pkg::TGT_DMA;
        dec.dma    = 1'b1;
      end else if (address == cbad_pkg::PAD0_ADDR) begin
        dec.target     = cbad_pkg::TGT_PAD;
        dec.pad_strobe = 1'b1;
      end
    end
  end

endmodule

/* rtl/core/cpu_bus_address_decoder.sv */
// ----------------------------------------------------------------------------
// cpu_bus_address_decoder
// CPU bus access decoder with mirrored work RAM and two pad shift registers.
// ----------------------------------------------------------------------------
// One bus access word is taken per cycle while in_stall is low, and each
// result word passes through stage 1 (the registered read of the work RAM)
// and then the output register. Work RAM (2 KB, mirrored over 0x0000-0x1FFF)
// holds no defined value until written and needs no clearing pass. Pad shift
// registers reset to zero; a write to 0x4016 latches both pads, reads of
// 0x4016/0x4017 return the top bit and shift left. PPU and mapper accesses
// and APU writes are forwarded with a target code; unmapped reads give 0.
// read_data is zero for forwarded reads.
// ----------------------------------------------------------------------------
module cpu_bus_address_decoder (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_pad0_buttons,
  input  logic [7:0]  in_pad1_buttons,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_target,
  output logic [15:0] out_forward_address,
  output logic [7:0]  out_forward_data,
  output logic [7:0]  out_read_data,
  output logic        out_dma_start,
  output logic [7:0]  out_dma_page
);

  cbad_pkg::dec_t dec;

  logic in_acc;
  logic s1_move;

  logic [cbad_pkg::DATA_W-1:0] ram_rdata;

  logic [1:0][cbad_pkg::DATA_W-1:0] pad_shift_r, pad_shift_nxt;
  logic                             pad_bit;

  // stage 1: RAM read in flight
  logic                        s1_valid_r, s1_valid_nxt;
  cbad_pkg::target_t           s1_target_r;
  logic [cbad_pkg::ADDR_W-1:0] s1_faddr_r;
  logic [cbad_pkg::DATA_W-1:0] s1_fdata_r;
  logic                        s1_ram_rd_r;
  logic                        s1_pad_bit_r;
  logic                        s1_dma_r;
  logic [cbad_pkg::DATA_W-1:0] s1_dma_page_r;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  cbad_pkg::target_t           out_target_r;
  logic [cbad_pkg::ADDR_W-1:0] out_faddr_r;
  logic [cbad_pkg::DATA_W-1:0] out_fdata_r;
  logic [cbad_pkg::DATA_W-1:0] out_rdata_r;
  logic                        out_dma_r;
  logic [cbad_pkg::DATA_W-1:0] out_dma_page_r;

  cbad_decode u_decode (
    .req_type (in_req_type),
    .address  (in_address),
    .dec      (dec)
  );

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  cbad_ram #(
    .WIDTH (cbad_pkg::DATA_W),
    .DEPTH (cbad_pkg::RAM_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .en    (in_acc && (dec.ram_rd || dec.ram_wr)),
    .we    (dec.ram_wr),
    .addr  (in_address[cbad_pkg::RAM_ADDR_BITS-1:0]),
    .wdata (in_write_data),
    .rdata (ram_rdata)
  );

  assign pad_bit = pad_shift_r[dec.pad_sel][cbad_pkg::DATA_W-1];

  always_comb begin
    pad_shift_nxt = pad_shift_r;
    if (in_acc && dec.pad_strobe) begin
      pad_shift_nxt[0] = in_pad0_buttons;
      pad_shift_nxt[1] = in_pad1_buttons;
    end else if (in_acc && dec.pad_rd) begin
      pad_shift_nxt[dec.pad_sel] = {pad_shift_r[dec.pad_sel][cbad_pkg::DATA_W-2:0], 1'b0};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_shift_r <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pad_shift_r <= pad_shift_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_target_r   <= dec.target;
      s1_faddr_r    <= dec.fwd_addr;
      s1_fdata_r    <= dec.fwd_data ? in_write_data : '0;
      s1_ram_rd_r   <= dec.ram_rd;
      s1_pad_bit_r  <= dec.pad_rd && pad_bit;
      s1_dma_r      <= dec.dma;
      s1_dma_page_r <= dec.dma ? in_write_data : '0;
    end
    if (s1_move) begin
      out_target_r   <= s1_target_r;
      out_faddr_r    <= s1_faddr_r;
      out_fdata_r    <= s1_fdata_r;
      out_rdata_r    <= s1_ram_rd_r ? ram_rdata
                                    : {{(cbad_pkg::DATA_W-1){1'b0}}, s1_pad_bit_r};
      out_dma_r      <= s1_dma_r;
      out_dma_page_r <= s1_dma_page_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_target          = out_target_r;
  assign out_forward_address = out_faddr_r;
  assign out_forward_data    = out_fdata_r;
  assign out_read_data       = out_rdata_r;
  assign out_dma_start       = out_dma_r;
  assign out_dma_page        = out_dma_page_r;

`include "cpu_bus_address_decoder_assert.svh"

  `CBAD_ASSERT_NXT(a_strobe_latch, in_acc && dec.pad_strobe, pad_shift_r[0] == $past(in_pad0_buttons) && pad_shift_r[1] == $past(in_pad1_buttons))
  `CBAD_ASSERT_NXT(a_s1_to_out, s1_move, out_valid_r)
  `CBAD_ASSERT_IMP(a_dma_target, out_valid_r && out_dma_r, out_target_r == cbad_pkg::TGT_DMA)
  `CBAD_ASSERT_IMP(a_rdata_narrow, out_valid_r && out_target_r != cbad_pkg::TGT_RAM, out_rdata_r[cbad_pkg::DATA_W-1:1] == '0)
  `CBAD_ASSERT_IMP(a_ppu_reg, out_valid_r && out_target_r == cbad_pkg::TGT_PPU, out_faddr_r[cbad_pkg::ADDR_W-1:3] == '0)

endmodule
